// ===== rtl/sorted_block_device_table_assert.svh =====
// assertion macros for the sorted block/device table
`ifndef SORTED_BLOCK_DEVICE_TABLE_ASSERT_SVH
`define SORTED_BLOCK_DEVICE_TABLE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define SBDT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define SBDT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SBDT_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define SBDT_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== rtl/sbdt_pkg.sv =====
// shared types and constants for the sorted block/device table
package sbdt_pkg;

   localparam int unsigned DEFAULT_TABLE_DEPTH = 256;
   localparam int unsigned ENTRY_BYTES = 8;
   localparam int unsigned ENTRY_W = ENTRY_BYTES * 8;
   localparam int unsigned KEY_W = 32;
   localparam int unsigned POS_W = 9;

   typedef struct packed {
      logic             operation;
      logic [KEY_W-1:0] block_number;
      logic [KEY_W-1:0] device_number;
      logic [POS_W-1:0] insert_position;
   } req_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] position;
      logic             status;
      logic [POS_W-1:0] entry_count;
   } rsp_type;

   localparam logic OP_SEARCH = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   typedef enum logic [1:0] {
      FIN_FOUND,
      FIN_MISS,
      FIN_FULL,
      FIN_INSERT
   } fin_kind_type;

   typedef struct packed {
      logic         load;
      logic         rd_search;
      logic         step;
      logic         rd_shift;
      logic         wr_shift;
      logic         wr_new;
      logic         finish;
      fin_kind_type kind;
   } ctrl_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic lo_gt_hi;
      logic entry_lt_key;
      logic entry_eq_key;
      logic mid_zero;
      logic more_shift;
   } stat_type;

endpackage

// ===== rtl/sbdt_ctrl.sv =====
// controller state machine for search and insert sequencing
module sbdt_ctrl import sbdt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic     req_operation,
   input  stat_type stat,
   output ctrl_type cmd,
   output logic     busy
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH_ADDR,
      ST_SEARCH_CMP,
      ST_INS_CHECK,
      ST_SHIFT_RD,
      ST_SHIFT_WR
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   always_comb begin
      cmd      = '0;
      cmd.kind = FIN_MISS;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && !busy_ff) begin
               cmd.load = 1'b1;
               state_in = (req_operation == OP_INSERT) ? ST_INS_CHECK : ST_SEARCH_ADDR;
            end
         end
         ST_SEARCH_ADDR: begin
            if (stat.empty || stat.lo_gt_hi) begin
               cmd.finish = 1'b1;
               cmd.kind   = FIN_MISS;
               state_in   = ST_IDLE;
            end else begin
               cmd.rd_search = 1'b1;
               state_in      = ST_SEARCH_CMP;
            end
         end
         ST_SEARCH_CMP: begin
            priority if (stat.entry_eq_key) begin
               cmd.finish = 1'b1;
               cmd.kind   = FIN_FOUND;
               state_in   = ST_IDLE;
            end else if (!stat.entry_lt_key && stat.mid_zero) begin
               // key sorts below entry zero: stop at left bound
               cmd.finish = 1'b1;
               cmd.kind   = FIN_MISS;
               state_in   = ST_IDLE;
            end else begin
               cmd.step = 1'b1;
               state_in = ST_SEARCH_ADDR;
            end
         end
         ST_INS_CHECK: begin
            if (stat.full) begin
               cmd.finish = 1'b1;
               cmd.kind   = FIN_FULL;
               state_in   = ST_IDLE;
            end else begin
               state_in = ST_SHIFT_RD;
            end
         end
         ST_SHIFT_RD: begin
            if (stat.more_shift) begin
               cmd.rd_shift = 1'b1;
               state_in     = ST_SHIFT_WR;
            end else begin
               cmd.wr_new = 1'b1;
               cmd.finish = 1'b1;
               cmd.kind   = FIN_INSERT;
               state_in   = ST_IDLE;
            end
         end
         ST_SHIFT_WR: begin
            cmd.wr_shift = 1'b1;
            state_in     = ST_SHIFT_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      busy_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

// ===== rtl/sbdt_datapath.sv =====
// table memory, search bounds, shift pointer and response register
module sbdt_datapath import sbdt_pkg::*; #(
   parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  ctrl_type cmd,
   output stat_type stat,
   output logic     rsp_strobe,
   output rsp_type  rsp_data
);

   localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
   localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned WIDE_W = CNT_W + POS_W;

   logic [ENTRY_W-1:0] entry_store_ff [TABLE_DEPTH];
   logic [ENTRY_W-1:0] rd_ff;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ENTRY_W-1:0] key_ff, key_in;
   logic [CNT_W-1:0]   lo_ff, lo_in;
   logic [CNT_W-1:0]   hi_ff, hi_in;
   logic [CNT_W-1:0]   mid_ff, mid_in;
   logic [CNT_W-1:0]   ptr_ff, ptr_in;
   logic [CNT_W-1:0]   ins_pos_ff, ins_pos_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [CNT_W:0]     bound_sum;
   logic [CNT_W-1:0]   mid_calc;
   logic [CNT_W-1:0]   ptr_m1;
   logic [WIDE_W-1:0]  ipos_wide;
   logic [WIDE_W-1:0]  count_wide;
   logic [CNT_W-1:0]   pos_src;
   logic [WIDE_W-1:0]  pos_wide;
   logic [WIDE_W-1:0]  count_in_wide;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_wa;
   logic [ENTRY_W-1:0] mem_wd;
   logic               mem_re;
   logic [IDX_W-1:0]   mem_ra;

   assign bound_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_calc  = bound_sum[CNT_W:1];
   assign ptr_m1    = ptr_ff - CNT_W'(1);
   assign ipos_wide  = WIDE_W'(req_data.insert_position);
   assign count_wide = WIDE_W'(count_ff);

   // status toward the controller
   assign stat.empty        = (count_ff == '0);
   assign stat.full         = (count_wide >= WIDE_W'(TABLE_DEPTH));
   assign stat.lo_gt_hi     = (lo_ff > hi_ff);
   assign stat.entry_lt_key = (rd_ff < key_ff);
   assign stat.entry_eq_key = (rd_ff == key_ff);
   assign stat.mid_zero     = (mid_ff == '0);
   assign stat.more_shift   = (ptr_ff > ins_pos_ff);

   always_comb begin
      key_in     = key_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      mid_in     = mid_ff;
      ptr_in     = ptr_ff;
      ins_pos_in = ins_pos_ff;
      count_in   = count_ff;

      if (cmd.load) begin
         key_in     = {req_data.block_number, req_data.device_number};
         lo_in      = '0;
         hi_in      = count_ff - CNT_W'(1);
         ptr_in     = count_ff;
         // positions past the count append
         ins_pos_in = (ipos_wide > count_wide) ? count_ff : ipos_wide[CNT_W-1:0];
      end
      if (cmd.rd_search) begin
         mid_in = mid_calc;
      end
      if (cmd.step) begin
         if (stat.entry_lt_key) begin
            lo_in = mid_ff + CNT_W'(1);
         end else begin
            hi_in = mid_ff - CNT_W'(1);
         end
      end
      if (cmd.wr_shift) begin
         ptr_in = ptr_m1;
      end
      if (cmd.wr_new) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   // memory port selection
   always_comb begin
      mem_re = cmd.rd_search || cmd.rd_shift;
      mem_ra = cmd.rd_shift ? ptr_m1[IDX_W-1:0] : mid_calc[IDX_W-1:0];
      mem_we = cmd.wr_shift || cmd.wr_new;
      mem_wa = cmd.wr_shift ? ptr_ff[IDX_W-1:0] : ins_pos_ff[IDX_W-1:0];
      mem_wd = cmd.wr_shift ? rd_ff : key_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_store_ff[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_ff <= entry_store_ff[mem_ra];
      end
   end

   // response formation
   always_comb begin
      unique case (cmd.kind)
         FIN_FOUND:  pos_src = mid_ff;
         FIN_MISS:   pos_src = lo_ff;
         FIN_FULL:   pos_src = '0;
         FIN_INSERT: pos_src = ins_pos_ff;
         default:    pos_src = '0;
      endcase
      pos_wide             = WIDE_W'(pos_src);
      count_in_wide        = WIDE_W'(count_in);
      rsp_in.found         = (cmd.kind == FIN_FOUND);
      rsp_in.position      = pos_wide[POS_W-1:0];
      rsp_in.status        = (cmd.kind == FIN_FULL);
      rsp_in.entry_count   = count_in_wide[POS_W-1:0];
      rsp_valid_in         = cmd.finish;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mid_ff     <= mid_in;
      ptr_ff     <= ptr_in;
      ins_pos_ff <= ins_pos_in;
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ===== rtl/sorted_block_device_table.sv =====
// search: each probe reads the table memory into a register, then compares the entry with the key;
//   the result strobe follows the last probe, after at most ceil(log2(TABLE_DEPTH+1)) probes
// insert: each entry moved up takes a memory read then a write; then the new entry is written
//   and the result formed; a refused insert on a full table answers after the full check
// one request at a time; busy is high from acceptance until the result is formed
// reset clears the entry count and control only; table contents stay undefined until written
`include "sorted_block_device_table_assert.svh"
module sorted_block_device_table import sbdt_pkg::*; #(
   parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   ctrl_type cmd;
   stat_type stat;

   sbdt_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_data.operation),
      .stat          (stat),
      .cmd           (cmd),
      .busy          (busy)
   );

   sbdt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   `SBDT_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy, "busy not raised after request")
   `SBDT_ASSERT_NXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe, "result strobe held")
   `SBDT_ASSERT_IMP(a_no_write_full, clock, reset, cmd.wr_new, !stat.full, "insert into full table")
   `SBDT_ASSERT_IMP(a_found_ok, clock, reset, rsp_strobe && rsp_data.found, !rsp_data.status, "found with error")

endmodule

// ===== sim/tb_sorted_block_device_table.sv =====
// testbench for the sorted block/device table: predicted responses, field checks, random traffic
module tb_sorted_block_device_table;
   import sbdt_pkg::*;

   localparam int TABLE_DEPTH    = DEFAULT_TABLE_DEPTH;
   localparam int CLOCK_PERIOD   = 8;
   localparam int TIMEOUT_CYCLES = 2_000_000;
   localparam int SETTLE_CYCLES  = 2 * TABLE_DEPTH + 88;
   localparam int PRINT_LIMIT    = 40;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   // shadow copy of the table
   logic [KEY_W-1:0] shadow_block [TABLE_DEPTH];
   logic [KEY_W-1:0] shadow_device [TABLE_DEPTH];
   int               shadow_count = 0;

   rsp_type pending_answers [$];
   rsp_type oldest_answer;
   int      error_count = 0;

   sorted_block_device_table #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   always begin
      #(CLOCK_PERIOD / 2) clock = 1'b1;
      #(CLOCK_PERIOD / 2) clock = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_LIMIT) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      error_count++;
   endtask

   // binary search with midpoint rounded down, stops at the first equal probe
   function automatic bit table_search(input logic [KEY_W-1:0] blk, input logic [KEY_W-1:0] dev,
                                       output int where);
      int lo;
      int hi;
      int mid;
      bit below;
      bit above;
      where = 0;
      if (shadow_count == 0) begin
         return 1'b0;
      end
      lo = 0;
      hi = shadow_count - 1;
      while (lo <= hi) begin
         mid   = (lo + hi) / 2;
         below = (shadow_block[mid] < blk) ||
                 (shadow_block[mid] == blk && shadow_device[mid] < dev);
         above = (shadow_block[mid] > blk) ||
                 (shadow_block[mid] == blk && shadow_device[mid] > dev);
         if (below) begin
            lo = mid + 1;
         end else if (above) begin
            if (mid == 0) begin
               break;
            end
            hi = mid - 1;
         end else begin
            where = mid;
            return 1'b1;
         end
      end
      where = lo;
      return 1'b0;
   endfunction

   function automatic rsp_type predict_outcome(input req_type item);
      rsp_type ans;
      int      where;
      int      i;
      ans = '0;
      if (item.operation == OP_SEARCH) begin
         ans.found    = table_search(item.block_number, item.device_number, where);
         ans.position = where[POS_W-1:0];
      end else if (shadow_count >= TABLE_DEPTH) begin
         ans.status   = 1'b1;
         ans.position = '0;
      end else begin
         where = (int'(item.insert_position) > shadow_count) ? shadow_count
                                                              : int'(item.insert_position);
         for (i = shadow_count; i > where; i--) begin
            shadow_block[i]  = shadow_block[i-1];
            shadow_device[i] = shadow_device[i-1];
         end
         shadow_block[where]  = item.block_number;
         shadow_device[where] = item.device_number;
         shadow_count++;
         ans.position = where[POS_W-1:0];
      end
      ans.entry_count = shadow_count[POS_W-1:0];
      return ans;
   endfunction

   function automatic req_type make_req(input logic op, input logic [KEY_W-1:0] blk,
                                        input logic [KEY_W-1:0] dev, input logic [POS_W-1:0] pos);
      req_type r;
      r.operation       = op;
      r.block_number    = blk;
      r.device_number   = dev;
      r.insert_position = pos;
      return r;
   endfunction

   // mix of a narrow pool, the extremes and full-range values so that keys collide
   function automatic logic [KEY_W-1:0] pick_key_field();
      int r;
      r = $urandom_range(99);
      if (r < 30) begin
         return KEY_W'($urandom_range(7));
      end else if (r < 40) begin
         return $urandom_range(1) ? '1 : '0;
      end
      return $urandom;
   endfunction

   task automatic send_request(input req_type item);
      start    <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      pending_answers.push_back(predict_outcome(item));
   endtask

   task automatic idle_gap(input int pct);
      if ($urandom_range(99) < pct) begin
         start <= 1'b0;
         do begin
            @(posedge clock);
         end while ($urandom_range(99) < pct);
      end
   endtask

   task automatic drain_answers();
      start <= 1'b0;
      while (pending_answers.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic search_key(input logic [KEY_W-1:0] blk, input logic [KEY_W-1:0] dev);
      send_request(make_req(OP_SEARCH, blk, dev, POS_W'($urandom_range(511))));
   endtask

   // insert at the slot that keeps the table ordered
   task automatic insert_sorted(input logic [KEY_W-1:0] blk, input logic [KEY_W-1:0] dev);
      int slot;
      void'(table_search(blk, dev, slot));
      send_request(make_req(OP_INSERT, blk, dev, slot[POS_W-1:0]));
   endtask

   task automatic test_directed_cases();
      search_key('1, '1);                                      // empty table
      send_request(make_req(OP_INSERT, 32'd100, 32'd5, '1));   // clamped to count
      search_key(32'd100, 32'd5);
      search_key(32'd0, 32'd0);
      search_key(32'd100, 32'd6);
      search_key('1, '1);
      send_request(make_req(OP_INSERT, '1, '1, 9'd256));       // clamped append
      send_request(make_req(OP_INSERT, '0, '0, 9'd0));
      insert_sorted(32'd100, 32'd0);
      insert_sorted(32'd100, '1);
      insert_sorted(32'd100, 32'd5);                           // duplicate
      insert_sorted('1, '0);
      search_key('0, '0);
      search_key('1, '1);
      search_key(32'd100, 32'd5);
      search_key(32'd100, 32'd4);
      search_key(32'h7fff_ffff, '0);
      search_key(32'd100, '1);
      search_key('1, 32'd1);
      search_key(32'd99, '1);
      drain_answers();
   endtask

   task automatic run_random_phase(input int n_items, input int idle_pct, input int noise_pct);
      int               k;
      int               r;
      int               idx;
      int               slot;
      logic [KEY_W-1:0] blk;
      logic [KEY_W-1:0] dev;
      logic [POS_W-1:0] pos;
      for (k = 0; k < n_items; k++) begin
         r   = $urandom_range(99);
         blk = pick_key_field();
         dev = pick_key_field();
         if (r < 45) begin
            // search, often for a held key or its near neighbor
            if (shadow_count > 0 && $urandom_range(1)) begin
               idx = $urandom_range(shadow_count - 1);
               blk = shadow_block[idx];
               dev = shadow_device[idx];
               if ($urandom_range(3) == 0) begin
                  dev = dev + ($urandom_range(1) ? 1 : -1);
               end
            end
            search_key(blk, dev);
         end else if (r < 45 + noise_pct) begin
            send_request(make_req(OP_INSERT, blk, dev, POS_W'($urandom_range(511))));
         end else begin
            void'(table_search(blk, dev, slot));
            pos = slot[POS_W-1:0];
            if (slot == shadow_count && $urandom_range(1)) begin
               pos = POS_W'($urandom_range(511, shadow_count));
            end
            send_request(make_req(OP_INSERT, blk, dev, pos));
         end
         if ($urandom_range(99) < 3) begin
            drain_answers();
         end else begin
            idle_gap(idle_pct);
         end
      end
      drain_answers();
   endtask

   task automatic test_random_traffic();
      run_random_phase(100, 0, 0);
      run_random_phase(100, 85, 0);
      run_random_phase(100, 0, 0);
      run_random_phase(100, 15, 10);
   endtask

   task automatic test_full_table();
      // wait for every outstanding response before filling
      drain_answers();
      while (shadow_count < TABLE_DEPTH) begin
         insert_sorted(pick_key_field(), pick_key_field());
         idle_gap(15);
      end
      search_key(shadow_block[0], shadow_device[0]);
      search_key(shadow_block[TABLE_DEPTH-1], shadow_device[TABLE_DEPTH-1]);
      search_key('1, '1);
      search_key('0, '0);
      send_request(make_req(OP_INSERT, '1, '1, '1));
      send_request(make_req(OP_INSERT, '0, '0, 9'd0));
      send_request(make_req(OP_INSERT, 32'd3, 32'd3, 9'd256));
      search_key(pick_key_field(), pick_key_field());
      drain_answers();
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_answers.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            oldest_answer = pending_answers.pop_front();
            if (rsp_data.found !== oldest_answer.found) begin
               report_mismatch($sformatf("found expected %0d got %0d",
                                         oldest_answer.found, rsp_data.found));
            end
            if (rsp_data.position !== oldest_answer.position) begin
               report_mismatch($sformatf("position expected %0d got %0d",
                                         oldest_answer.position, rsp_data.position));
            end
            if (rsp_data.status !== oldest_answer.status) begin
               report_mismatch($sformatf("status expected %0d got %0d",
                                         oldest_answer.status, rsp_data.status));
            end
            if (rsp_data.entry_count !== oldest_answer.entry_count) begin
               report_mismatch($sformatf("entry_count expected %0d got %0d",
                                         oldest_answer.entry_count, rsp_data.entry_count));
            end
         end
      end
   end

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_random_traffic();
      test_full_table();
      drain_answers();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_answers.size() != 0) begin
         report_mismatch($sformatf("%0d responses never arrived", pending_answers.size()));
      end
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/sbdt_pkg.sv
rtl/sbdt_ctrl.sv
rtl/sbdt_datapath.sv
rtl/sorted_block_device_table.sv
sim/tb_sorted_block_device_table.sv
